/* rtl/lfg_pkg.sv */
// shared types and constants for the largest free gap fit check
package lfg_pkg;

	localparam int POS_W         = 12;
	localparam int GAP_W         = 12;
	localparam int POSITIONS_DEF = 4096;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] block_size;
	} req_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
		logic fits;
	} eng_st_t;

endpackage

/* rtl/lfg_engine.sv */
// gap tree memory and the sequencer that walks it
module lfg_engine #(
	parameter int POSITIONS = lfg_pkg::POSITIONS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  lfg_pkg::req_t  req,
	input  logic           res_take,
	output lfg_pkg::eng_st_t st
);
	import lfg_pkg::*;

	localparam int PW = $clog2(POSITIONS);
	localparam int NW = PW + 1;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_PL_RD, S_PL_CK, S_PU, S_PU_CK, S_PD, S_PD_CK,
		S_SU, S_SU_CK, S_SD, S_SD_CK, S_WL, S_WU, S_WU_CK,
		S_PM_RD, S_PM_CK, S_PMU, S_PMU_CK, S_FIN
	} state_t;

	state_t           state_q;
	logic [NW-1:0]    nd_q;
	logic [NW-1:0]    clr_q;
	logic             cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] size_q;
	logic [PW-1:0]    tq_q;
	logic [PW-1:0]    prv_q;
	logic [PW-1:0]    succ_q;
	logic             sfound_q;
	logic [GAP_W-1:0] acc_q;
	logic [GAP_W-1:0] wv_q;
	logic             fits_q;

	logic [GAP_W-1:0] mem [2*POSITIONS];
	logic [GAP_W-1:0] rdata_q;
	logic [NW-1:0]    mem_raddr;
	logic [NW-1:0]    mem_waddr;
	logic [GAP_W-1:0] mem_wdata;
	logic             mem_we;

	logic             nz;
	logic             pos_over;
	logic [PW-1:0]    t_in;
	logic [GAP_W-1:0] wmax;
	logic [GAP_W-1:0] amax;
	logic [GAP_W-1:0] tail;
	logic [GAP_W-1:0] best;

	function automatic logic [NW-1:0] leaf_of(logic [PW-1:0] p);
		return {1'b1, p};
	endfunction

	assign nz       = rdata_q != '0;
	assign pos_over = 32'(req.position) >= POSITIONS;
	assign t_in     = pos_over ? PW'(POSITIONS - 1) : PW'(req.position);
	assign wmax     = (wv_q > rdata_q) ? wv_q : rdata_q;
	assign amax     = (acc_q > rdata_q) ? acc_q : rdata_q;
	assign tail     = pos_q - GAP_W'(prv_q);
	assign best     = (acc_q > tail) ? acc_q : tail;

	always_comb begin
		mem_raddr = leaf_of(tq_q);
		mem_waddr = nd_q;
		mem_wdata = wv_q;
		mem_we    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_PU, S_PMU: mem_raddr = nd_q - NW'(1);
			S_SU:        mem_raddr = nd_q + NW'(1);
			S_PD:        mem_raddr = {nd_q[NW-2:0], 1'b1};
			S_SD:        mem_raddr = {nd_q[NW-2:0], 1'b0};
			S_WU:        mem_raddr = nd_q ^ NW'(1);
			S_PM_RD:     mem_raddr = leaf_of(prv_q);
			S_WL:        mem_we    = 1'b1;
			S_WU_CK: begin
				mem_we    = 1'b1;
				mem_waddr = nd_q >> 1;
				mem_wdata = wmax;
			end
			default: mem_raddr = leaf_of(tq_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			sfound_q <= 1'b0;
			fits_q   <= 1'b0;
			nd_q     <= '0;
			cmd_q    <= CMD_PLACE;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q  <= req.cmd;
						pos_q  <= req.position;
						size_q <= req.block_size;
						tq_q   <= t_in;
						if (!(req.cmd == CMD_PLACE && pos_over)) begin
							state_q <= S_PL_RD;
						end
					end
				end
				S_PL_RD: state_q <= S_PL_CK;
				S_PL_CK: begin
					if (nz || tq_q == '0) begin
						if (cmd_q == CMD_PLACE) begin
							state_q <= S_IDLE;
						end else begin
							prv_q   <= tq_q;
							state_q <= S_PM_RD;
						end
					end else begin
						nd_q    <= leaf_of(tq_q);
						state_q <= S_PU;
					end
				end
				S_PU: begin
					if (nd_q == NW'(1)) begin
						prv_q    <= '0;
						nd_q     <= leaf_of(tq_q);
						sfound_q <= 1'b0;
						state_q  <= (cmd_q == CMD_PLACE) ? S_SU : S_PM_RD;
					end else if (nd_q[0]) begin
						state_q <= S_PU_CK;
					end else begin
						nd_q <= nd_q >> 1;
					end
				end
				S_PU_CK: begin
					if (nz) begin
						nd_q    <= nd_q - NW'(1);
						state_q <= S_PD;
					end else begin
						nd_q    <= nd_q >> 1;
						state_q <= S_PU;
					end
				end
				S_PD: begin
					if (nd_q[NW-1]) begin
						prv_q    <= nd_q[PW-1:0];
						nd_q     <= leaf_of(tq_q);
						sfound_q <= 1'b0;
						state_q  <= (cmd_q == CMD_PLACE) ? S_SU : S_PM_RD;
					end else begin
						state_q <= S_PD_CK;
					end
				end
				S_PD_CK: begin
					nd_q    <= {nd_q[NW-2:0], nz};
					state_q <= S_PD;
				end
				S_SU: begin
					if (nd_q == NW'(1)) begin
						wv_q    <= pos_q - GAP_W'(prv_q);
						nd_q    <= leaf_of(tq_q);
						state_q <= S_WL;
					end else if (!nd_q[0]) begin
						state_q <= S_SU_CK;
					end else begin
						nd_q <= nd_q >> 1;
					end
				end
				S_SU_CK: begin
					if (nz) begin
						nd_q    <= nd_q + NW'(1);
						state_q <= S_SD;
					end else begin
						nd_q    <= nd_q >> 1;
						state_q <= S_SU;
					end
				end
				S_SD: begin
					if (nd_q[NW-1]) begin
						succ_q   <= nd_q[PW-1:0];
						sfound_q <= 1'b1;
						wv_q     <= pos_q - GAP_W'(prv_q);
						nd_q     <= leaf_of(tq_q);
						state_q  <= S_WL;
					end else begin
						state_q <= S_SD_CK;
					end
				end
				S_SD_CK: begin
					nd_q    <= {nd_q[NW-2:0], !nz};
					state_q <= S_SD;
				end
				S_WL: state_q <= S_WU;
				S_WU: begin
					if (nd_q == NW'(1)) begin
						if (sfound_q) begin
							sfound_q <= 1'b0;
							wv_q     <= GAP_W'(succ_q) - pos_q;
							nd_q     <= leaf_of(succ_q);
							state_q  <= S_WL;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_WU_CK;
					end
				end
				S_WU_CK: begin
					wv_q    <= wmax;
					nd_q    <= nd_q >> 1;
					state_q <= S_WU;
				end
				S_PM_RD: state_q <= S_PM_CK;
				S_PM_CK: begin
					acc_q   <= rdata_q;
					nd_q    <= leaf_of(prv_q);
					state_q <= S_PMU;
				end
				S_PMU: begin
					if (nd_q == NW'(1)) begin
						fits_q  <= best >= size_q;
						state_q <= S_FIN;
					end else if (nd_q[0]) begin
						state_q <= S_PMU_CK;
					end else begin
						nd_q <= nd_q >> 1;
					end
				end
				S_PMU_CK: begin
					acc_q   <= amax;
					nd_q    <= nd_q >> 1;
					state_q <= S_PMU;
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign st.idle      = state_q == S_IDLE;
	assign st.res_valid = state_q == S_FIN;
	assign st.fits      = fits_q;

	a_no_root_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLR && mem_we) |-> mem_waddr != '0)
		else $error("tree write to unused node");

	a_leaf_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WL |-> (mem_wdata != '0 && mem_waddr[NW-1]))
		else $error("obstacle leaf written with zero gap");

	a_res_query: assert property (@(posedge clk) disable iff (!arst_n)
		st.res_valid |-> cmd_q == CMD_QUERY)
		else $error("result raised for a place");

endmodule

/* rtl/largest_free_gap_fit_check.sv */
// top level: transfer handshakes and result register around the gap tree engine
// A place command adds an obstacle and gives no result; a query gives one fits result.
// The gaps live in one 2*POSITIONS by 12 bit tree memory (POSITIONS a power of two) with a
// registered read port, walked one node at a time. A query finds the last obstacle at or
// before its position and then walks from that leaf to the root. A new place walks to
// its predecessor and successor and then does one or two leaf-to-root rewrites. A place
// on an existing obstacle ends after its leaf read. One item is worked at a time.
// After reset the memory is cleared, one node a cycle, before the first item is taken.
// A finished result waits in the output register while the next item is taken.
module largest_free_gap_fit_check #(
	parameter int POSITIONS = lfg_pkg::POSITIONS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     cmd,
	input  logic [lfg_pkg::POS_W-1:0] position,
	input  logic [lfg_pkg::POS_W-1:0] block_size,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     fits
);
	import lfg_pkg::*;

	req_t    req;
	eng_st_t st;
	logic    accept;
	logic    res_take;
	logic    out_valid_q;
	logic    fits_q;

	assign req.cmd        = cmd;
	assign req.position   = position;
	assign req.block_size = block_size;

	assign in_stall = !st.idle;
	assign accept   = in_valid && !in_stall;
	assign res_take = st.res_valid && (!out_valid_q || !out_stall);

	lfg_engine #(
		.POSITIONS(POSITIONS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(accept),
		.req      (req),
		.res_take (res_take),
		.st       (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fits_q      <= 1'b0;
		end else begin
			if (res_take) begin
				out_valid_q <= 1'b1;
				fits_q      <= st.fits;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign fits      = fits_q;

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_QUERY) |=> in_stall)
		else $error("query transfer did not start the engine");

endmodule

/* bench/tb_largest_free_gap_fit_check.sv */
// testbench for the largest free gap fit check: directed and random place and query traffic against a predictor
class fit_scoreboard;
	bit obstacle [4096];
	bit fits_due [$];
	int errors;
	int queries;
	int places;

	function void clear_line();
		foreach (obstacle[i]) obstacle[i] = 0;
		obstacle[0] = 1;
	endfunction

	// largest gap among obstacles at or before lim plus the tail gap to pos
	function bit fits_for(int pos, int size);
		int lim;
		int prv;
		int best;
		lim = pos;
		if (lim > 4095) lim = 4095;
		prv = 0;
		best = 0;
		for (int i = 1; i <= lim; i++) begin
			if (obstacle[i]) begin
				if (i - prv > best) best = i - prv;
				prv = i;
			end
		end
		if (pos - prv > best) best = pos - prv;
		return best >= size;
	endfunction

	function void note_input(bit c, int pos, int size);
		if (c == lfg_pkg::CMD_PLACE) begin
			places++;
			obstacle[pos] = 1;
		end else begin
			queries++;
			fits_due = {fits_due, fits_for(pos, size)};
		end
	endfunction

	function bit check_result(bit got, output string msg);
		bit want;
		if (fits_due.size() == 0) begin
			msg = "result with no query waiting";
			return 0;
		end
		want = fits_due.pop_front();
		if (got !== want) begin
			$sformat(msg, "fits got %0b want %0b", got, want);
			return 0;
		end
		return 1;
	endfunction
endclass

module tb_largest_free_gap_fit_check;
	import lfg_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic cmd = 0;
	logic [POS_W-1:0] position = 1;
	logic [POS_W-1:0] block_size = 1;
	logic out_valid;
	logic out_stall = 0;
	logic fits;

	fit_scoreboard sb = new();
	int cycles = 0;
	int fail_count = 0;
	bit calm = 0;
	bit hold_off = 0;

	largest_free_gap_fit_check DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.position(position), .block_size(block_size), .out_valid(out_valid),
		.out_stall(out_stall), .fits(fits)
	);

	always #6 clk = ~clk;

	task report(string msg);
		$display("error at cycle %0d: %s", cycles, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("timeout with %0d results pending", sb.fits_due.size());
			$display("largest_free_gap_fit_check: mismatch");
			$finish;
		end
	end

	// result side
	always @(posedge clk) begin
		string msg;
		if (arst_n && out_valid && !out_stall) begin
			if (!sb.check_result(fits, msg)) report(msg);
		end
		out_stall <= hold_off || (!calm && $urandom_range(99) < 28);
	end

	// one transfer, with random idle cycles before it
	task send(bit c, int pos, int size);
		while (!calm && $urandom_range(99) < 28) begin
			in_valid <= 0;
			@(posedge clk);
		end
		cmd <= c;
		position <= POS_W'(pos);
		block_size <= POS_W'(size);
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(c, pos, size);
	endtask

	task stop_input();
		in_valid <= 0;
	endtask

	task drain();
		while (sb.fits_due.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task send_random(int n, int span);
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(span, 1);
			if ($urandom_range(99) < 35)
				send(CMD_PLACE, p, 1);
			else if ($urandom_range(9) == 0)
				send(CMD_QUERY, p, $urandom_range(4095, 1));
			else
				send(CMD_QUERY, p, $urandom_range(p < 64 ? 64 : p, 1));
		end
	endtask

	initial begin
		sb.clear_line();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		// directed: empty line, extremes, repeated place, tail gap
		send(CMD_QUERY, 4095, 4095);
		send(CMD_QUERY, 1, 1);
		send(CMD_QUERY, 1, 2);
		send(CMD_QUERY, 4095, 4096 - 1);
		send(CMD_PLACE, 4095, 1);
		send(CMD_QUERY, 4095, 4095);
		send(CMD_QUERY, 4094, 4094);
		send(CMD_PLACE, 4095, 1);
		send(CMD_PLACE, 1, 1);
		send(CMD_PLACE, 1, 1);
		send(CMD_QUERY, 1, 1);
		send(CMD_QUERY, 2, 1);
		send(CMD_PLACE, 2048, 1);
		send(CMD_QUERY, 4095, 2048);
		send(CMD_QUERY, 4095, 2047);
		send(CMD_QUERY, 2047, 2046);
		send(CMD_PLACE, 2730, 1);
		send(CMD_QUERY, 3000, 1365);
		send(CMD_QUERY, 3000, 2048);
		send(CMD_QUERY, 2730, 1366);
		stop_input();
		drain();
		// pressure: receiver holds off while items keep coming
		hold_off = 1;
		fork
			begin repeat (600) @(posedge clk); hold_off = 0; end
			begin send_random(30, 4095); stop_input(); end
		join
		drain();
		send_random(600, 4095);
		calm = 1;
		send_random(300, 300);
		calm = 0;
		stop_input();
		drain();
		send_random(770, 4095);
		stop_input();
		drain();
		$display("covered %0d places and %0d queries", sb.places, sb.queries);
		$display("with receiver hold-off, random idling and idle-free stretches");
		if (fail_count == 0)
			$display("largest_free_gap_fit_check: match");
		else
			$display("largest_free_gap_fit_check: mismatch");
		$finish;
	end
endmodule
